// ===== rtl/sample_voice_mixer_macros.svh =====
// Assertion macros for the sample voice mixer.
// Used by the RTL files that carry concurrent checks; relies on clk and rst_n in scope.
`ifndef SAMPLE_VOICE_MIXER_MACROS_SVH
`define SAMPLE_VOICE_MIXER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SVM_ASSERT_IMPL(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);
`define SVM_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);
`else
`define SVM_ASSERT_IMPL(label, cond, prop, msg)
`define SVM_ASSERT_NEXT(label, cond, prop, msg)
`endif
`endif

// ===== rtl/svm_pkg.sv =====
// Shared types and constants for the sample voice mixer.
// No dependencies.
`timescale 1ns / 1ps
package svm_pkg;
  localparam int DEF_VOICES       = 16;
  localparam int DEF_SAMPLE_WORDS = 65536;

  localparam int OP_W    = 2;
  localparam int VSEL_W  = 4;
  localparam int ADDR_W  = 16;
  localparam int SMP_W   = 16;
  localparam int LEN_W   = 16;
  localparam int VOL_W   = 9;
  localparam int PAN_W   = 10;
  localparam int RATE_W  = 18;
  localparam int PH_W    = 16;
  localparam int WGT_W   = 10;
  localparam int MASK_W  = 16;

  // shared multiplier operand / product widths
  localparam int MUL_W  = 28;
  localparam int PROD_W = 2 * MUL_W;
  localparam int FRAC_SH = 34;

  localparam logic [VOL_W-1:0] MASTER_RESET = 9'd256;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE  = 2'd0,
    OP_START  = 2'd1,
    OP_STOP   = 2'd2,
    OP_RENDER = 2'd3
  } op_t;
endpackage

// ===== rtl/svm_if.sv =====
// Valid/ready channel interfaces for the sample voice mixer.
// Depends on svm_pkg for field widths.
`timescale 1ns / 1ps
interface svm_in_if;
  logic                              valid;
  logic                              ready;
  logic [svm_pkg::OP_W-1:0]          op;
  logic [svm_pkg::VSEL_W-1:0]        voice;
  logic [svm_pkg::ADDR_W-1:0]        addr;
  logic signed [svm_pkg::SMP_W-1:0]  sample;
  logic [svm_pkg::LEN_W-1:0]         length;
  logic                              loop_enable;
  logic [svm_pkg::LEN_W-1:0]         loop_point;
  logic [svm_pkg::VOL_W-1:0]         volume;
  logic signed [svm_pkg::PAN_W-1:0]  pan;
  logic [svm_pkg::RATE_W-1:0]        rate;
  modport source (output valid, op, voice, addr, sample, length, loop_enable, loop_point,
                  volume, pan, rate, input ready);
  modport sink (input valid, op, voice, addr, sample, length, loop_enable, loop_point,
                volume, pan, rate, output ready);
endinterface

interface svm_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [svm_pkg::SMP_W-1:0]  left;
  logic signed [svm_pkg::SMP_W-1:0]  right;
  logic [svm_pkg::MASK_W-1:0]        active_voices;
  modport source (output valid, left, right, active_voices, input ready);
  modport sink (input valid, left, right, active_voices, output ready);
endinterface

// ===== rtl/svm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module svm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end
endmodule

// ===== rtl/svm_mul.sv =====
// Shared signed multiplier with registered product.
// Depends on svm_pkg for operand widths.
`timescale 1ns / 1ps
module svm_mul (
  input  logic                              clk,
  input  logic signed [svm_pkg::MUL_W-1:0]  a,
  input  logic signed [svm_pkg::MUL_W-1:0]  b,
  output logic signed [svm_pkg::PROD_W-1:0] prod_r
);
  import svm_pkg::*;

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(a) * PROD_W'(b);
  end
endmodule

// ===== rtl/sample_voice_mixer.sv =====
// Top level of the sample voice mixer: sequencer, voice state, accumulators.
// Depends on svm_pkg, svm_if, svm_ram, svm_mul and the assertion macro header.
`timescale 1ns / 1ps
`include "sample_voice_mixer_macros.svh"
// Write, start and stop transactions are handled in the idle state. A render walks all
// VOICES voices through one shared multiplier and the single read port of sample
// memory: an idle voice is only checked, while a playing voice takes two sample reads,
// seven multiplies and two accumulates; the render then saturates and posts the result.
// The result sits in an output register; new transactions are taken while it waits,
// and a further render holds in its final state until the register is free.
// Sample memory has no reset; reading an unwritten word returns garbage.
module sample_voice_mixer #(
  parameter int VOICES       = svm_pkg::DEF_VOICES,
  parameter int SAMPLE_WORDS = svm_pkg::DEF_SAMPLE_WORDS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  svm_in_if.sink                      in_chan,
  svm_out_if.source                   out_chan,
  input  logic                        cfg_we,
  input  logic [svm_pkg::VOL_W-1:0]   cfg_wdata
);
  import svm_pkg::*;

  localparam int VIW   = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int AW    = $clog2(SAMPLE_WORDS);
  localparam int ACC_W = PROD_W + VIW + 1;
  localparam int SH_W  = ACC_W - FRAC_SH;
  localparam logic [VIW-1:0] LAST_V = VIW'(VOICES - 1);
  localparam logic signed [SH_W-1:0] SAT_HI = SH_W'(32767);
  localparam logic signed [SH_W-1:0] SAT_LO = SH_W'(-32768);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_RD1, S_DIFF, S_VAL, S_GL, S_ML, S_AL, S_GR, S_MR, S_AR, S_DONE
  } state_t;

  state_t state_r;
  logic [VIW-1:0] vidx_r;
  logic [VOL_W-1:0] master_r;
  logic out_valid_r;
  logic signed [SMP_W-1:0] left_r, right_r;
  logic [MASK_W-1:0] mask_r;

  logic                    active_r [VOICES];
  logic [ADDR_W-1:0]       base_r   [VOICES];
  logic [LEN_W-1:0]        len_r    [VOICES];
  logic                    loop_r   [VOICES];
  logic [LEN_W-1:0]        lpt_r    [VOICES];
  logic [LEN_W-1:0]        pos_r    [VOICES];
  logic [PH_W-1:0]         ph_r     [VOICES];
  logic [VOL_W-1:0]        gain_r   [VOICES];
  logic signed [PAN_W-1:0] bal_r    [VOICES];
  logic [RATE_W-1:0]       step_r   [VOICES];

  logic signed [SMP_W-1:0] s0_r;
  logic signed [MUL_W-1:0] val_r;
  logic [LEN_W:0]          psum_r;
  logic signed [ACC_W-1:0] acc_l_r, acc_r_r;

  logic in_acc, out_acc;
  logic [VSEL_W+2:0] vsel_ext;
  logic vsel_ok;
  logic [VIW-1:0] vsel;

  logic ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [SMP_W-1:0] ram_rdata;

  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;

  logic [ADDR_W:0] addr_sum;
  logic signed [PAN_W:0] pan_c;
  logic [VOL_W-1:0] side_l, side_r;
  logic signed [SMP_W:0] diff;
  logic [RATE_W:0] ph_sum;
  logic signed [SH_W-1:0] sh_l, sh_r;
  logic [MASK_W-1:0] mask_nxt;

  function automatic logic [AW-1:0] wrap_addr(input logic [ADDR_W:0] x);
    logic [27:0] r;
    r = 28'(x);
    for (int k = 7; k >= 0; k--) begin
      if (r >= (28'(SAMPLE_WORDS) << k)) begin
        r = r - (28'(SAMPLE_WORDS) << k);
      end
    end
    return r[AW-1:0];
  endfunction

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_acc  = in_chan.valid && in_chan.ready;
  assign out_acc = out_valid_r && out_chan.ready;
  assign out_chan.valid = out_valid_r;
  assign out_chan.left  = left_r;
  assign out_chan.right = right_r;
  assign out_chan.active_voices = mask_r;

  assign vsel_ext = (VSEL_W + 3)'(in_chan.voice);
  assign vsel_ok  = vsel_ext < (VSEL_W + 3)'(VOICES);
  assign vsel     = VIW'(in_chan.voice);

  assign addr_sum = (ADDR_W + 1)'(base_r[vidx_r]) + (ADDR_W + 1)'(pos_r[vidx_r]);

  // clamp pan to unity, split volume between sides
  always_comb begin
    if (bal_r[vidx_r] > 10'sd256) begin
      pan_c = 11'sd256;
    end else if (bal_r[vidx_r] < -10'sd256) begin
      pan_c = -11'sd256;
    end else begin
      pan_c = (PAN_W + 1)'(bal_r[vidx_r]);
    end
    side_l = (pan_c < 0) ? VOL_W'(11'sd256 + pan_c) : 9'd256;
    side_r = (pan_c > 0) ? VOL_W'(11'sd256 - pan_c) : 9'd256;
  end

  assign diff   = (SMP_W + 1)'($signed(ram_rdata)) - (SMP_W + 1)'(s0_r);
  assign ph_sum = (RATE_W + 1)'(ph_r[vidx_r]) + (RATE_W + 1)'(step_r[vidx_r]);

  always_comb begin
    ram_we    = in_acc && (in_chan.op == OP_WRITE);
    ram_waddr = wrap_addr((ADDR_W + 1)'(in_chan.addr));
    ram_re    = (state_r == S_CHECK) || (state_r == S_RD1);
    ram_raddr = (state_r == S_RD1) ? wrap_addr(addr_sum + 1'b1) : wrap_addr(addr_sum);
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_DIFF: begin
        mul_a = MUL_W'(diff);
        mul_b = $signed(MUL_W'(ph_r[vidx_r][PH_W-1 -: WGT_W]));
      end
      S_VAL: begin
        mul_a = $signed(MUL_W'(side_l));
        mul_b = $signed(MUL_W'(gain_r[vidx_r]));
      end
      S_AL: begin
        mul_a = $signed(MUL_W'(side_r));
        mul_b = $signed(MUL_W'(gain_r[vidx_r]));
      end
      S_GL, S_GR: begin
        mul_a = $signed(prod[MUL_W-1:0]);
        mul_b = $signed(MUL_W'(master_r));
      end
      S_ML, S_MR: begin
        mul_a = val_r;
        mul_b = $signed(prod[MUL_W-1:0]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    sh_l = SH_W'(acc_l_r >>> FRAC_SH);
    sh_r = SH_W'(acc_r_r >>> FRAC_SH);
    mask_nxt = '0;
    for (int i = 0; i < VOICES && i < MASK_W; i++) begin
      mask_nxt[i] = active_r[i];
    end
  end

  svm_ram #(.WIDTH(SMP_W), .DEPTH(SAMPLE_WORDS)) u_smem (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (in_chan.sample),
    .re      (ram_re),
    .raddr   (ram_raddr),
    .rdata_r (ram_rdata)
  );

  svm_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod)
  );

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vidx_r      <= '0;
      master_r    <= MASTER_RESET;
      out_valid_r <= 1'b0;
      for (int i = 0; i < VOICES; i++) begin
        active_r[i] <= 1'b0;
      end
    end else begin
      if (cfg_we) begin
        master_r <= cfg_wdata;
      end
      if (out_acc) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_chan.op == OP_START && vsel_ok) begin
              active_r[vsel] <= 1'b1;
            end
            if (in_chan.op == OP_STOP && vsel_ok) begin
              active_r[vsel] <= 1'b0;
            end
            if (in_chan.op == OP_RENDER) begin
              vidx_r  <= '0;
              state_r <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          if (active_r[vidx_r]) begin
            state_r <= S_RD1;
          end else if (vidx_r == LAST_V) begin
            state_r <= S_DONE;
          end else begin
            vidx_r <= vidx_r + 1'b1;
          end
        end
        S_RD1:  state_r <= S_DIFF;
        S_DIFF: state_r <= S_VAL;
        S_VAL:  state_r <= S_GL;
        S_GL:   state_r <= S_ML;
        S_ML:   state_r <= S_AL;
        S_AL:   state_r <= S_GR;
        S_GR:   state_r <= S_MR;
        S_MR:   state_r <= S_AR;
        S_AR: begin
          if (psum_r >= (LEN_W + 1)'(len_r[vidx_r]) && !loop_r[vidx_r]) begin
            active_r[vidx_r] <= 1'b0;
          end
          if (vidx_r == LAST_V) begin
            state_r <= S_DONE;
          end else begin
            vidx_r  <= vidx_r + 1'b1;
            state_r <= S_CHECK;
          end
        end
        S_DONE: begin
          if (!out_valid_r) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // voice payload and datapath registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_acc && in_chan.op == OP_START && vsel_ok) begin
      base_r[vsel] <= in_chan.addr;
      len_r[vsel]  <= in_chan.length;
      loop_r[vsel] <= in_chan.loop_enable;
      lpt_r[vsel]  <= in_chan.loop_point;
      gain_r[vsel] <= in_chan.volume;
      bal_r[vsel]  <= in_chan.pan;
      step_r[vsel] <= in_chan.rate;
      pos_r[vsel]  <= '0;
      ph_r[vsel]   <= '0;
    end
    if (state_r == S_IDLE && in_acc && in_chan.op == OP_RENDER) begin
      acc_l_r <= '0;
      acc_r_r <= '0;
    end
    if (state_r == S_RD1) begin
      s0_r <= $signed(ram_rdata);
    end
    if (state_r == S_VAL) begin
      val_r <= (MUL_W'(s0_r) <<< WGT_W) + $signed(prod[MUL_W-1:0]);
    end
    if (state_r == S_AL) begin
      acc_l_r <= acc_l_r + ACC_W'(prod);
      ph_r[vidx_r] <= ph_sum[PH_W-1:0];
      psum_r <= (LEN_W + 1)'(pos_r[vidx_r]) + (LEN_W + 1)'(ph_sum[RATE_W:PH_W]);
    end
    if (state_r == S_AR) begin
      acc_r_r <= acc_r_r + ACC_W'(prod);
      if (psum_r >= (LEN_W + 1)'(len_r[vidx_r]) && loop_r[vidx_r]) begin
        pos_r[vidx_r] <= LEN_W'(psum_r - (LEN_W + 1)'(len_r[vidx_r])
                                + (LEN_W + 1)'(lpt_r[vidx_r]));
      end else begin
        pos_r[vidx_r] <= psum_r[LEN_W-1:0];
      end
    end
    if (state_r == S_DONE && !out_valid_r) begin
      left_r  <= (sh_l > SAT_HI) ? 16'sh7fff : (sh_l < SAT_LO) ? -16'sh8000 : SMP_W'(sh_l);
      right_r <= (sh_r > SAT_HI) ? 16'sh7fff : (sh_r < SAT_LO) ? -16'sh8000 : SMP_W'(sh_r);
      mask_r  <= mask_nxt;
    end
  end

  `SVM_ASSERT_IMPL(a_busy_not_ready, state_r != S_IDLE, !in_chan.ready, "ready while busy")
  `SVM_ASSERT_NEXT(a_done_posts, state_r == S_DONE && !out_valid_r, out_valid_r && state_r == S_IDLE, "render result not posted")
  `SVM_ASSERT_IMPL(a_vidx_range, state_r != S_IDLE, vidx_r <= LAST_V, "voice index out of range")
  `SVM_ASSERT_NEXT(a_render_starts, in_acc && in_chan.op == OP_RENDER, state_r == S_CHECK && vidx_r == '0, "render did not start walk")
endmodule
